@@ rtl/two_vector_active_lane_consolidation_assert.svh @@
// Assertion helpers for the lane consolidation block.
`ifndef TWO_VECTOR_ACTIVE_LANE_CONSOLIDATION_ASSERT_SVH
`define TWO_VECTOR_ACTIVE_LANE_CONSOLIDATION_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TVALC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TVALC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tvalc_pkg.sv @@
`timescale 1ns / 1ps
package tvalc_pkg;

  localparam int LANES  = 4;
  localparam int LANE_W = 32;
  localparam int IDX_W  = $clog2(LANES);
  localparam int CNT_W  = $clog2(LANES + 1);

  typedef logic signed [LANE_W-1:0] lane_t;
  typedef lane_t [LANES-1:0]        vec_t;
  typedef logic [LANES-1:0]         mask_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // Compaction of one vector: active lanes and inactive lanes, each packed low.
  typedef struct packed {
    vec_t act;
    vec_t inact;
    cnt_t act_cnt;
  } compact_t;

endpackage

@@ rtl/tvalc_compact.sv @@
`timescale 1ns / 1ps
module tvalc_compact (
  input  tvalc_pkg::vec_t     src,
  input  tvalc_pkg::mask_t    mask,
  output tvalc_pkg::compact_t res
);

  always_comb begin
    tvalc_pkg::cnt_t na;
    tvalc_pkg::cnt_t ni;
    na  = '0;
    ni  = '0;
    res = '0;
    // Prefix counts steer each lane to its packed slot.
    for (int i = 0; i < tvalc_pkg::LANES; i++) begin
      if (mask[i]) begin
        res.act[na[tvalc_pkg::IDX_W-1:0]] = src[i];
        na = na + tvalc_pkg::CNT_W'(1);
      end else begin
        res.inact[ni[tvalc_pkg::IDX_W-1:0]] = src[i];
        ni = ni + tvalc_pkg::CNT_W'(1);
      end
    end
    res.act_cnt = na;
  end

endmodule

@@ rtl/two_vector_active_lane_consolidation.sv @@
`timescale 1ns / 1ps
// Channel  | Handshake             | Payload
// in_      | in_valid / in_ready   | first_lane0..3, first_active, second_lane0..3, second_active
// out_     | out_valid / out_ready | packed_lane0..3, packed_valid, rest_lane0..3, rest_valid
//
// One transaction per cycle sustained unless out_ready stalls the result; each
// passes the input register, then the lane select network into the result register.
// rst_n is synchronous, active low, and clears only the two valid flags.
// A stalled result holds in the output register while the input register
// still takes one transaction; in_ready drops only when both are full.
module two_vector_active_lane_consolidation (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tvalc_pkg::lane_t    in_first_lane0,
  input  tvalc_pkg::lane_t    in_first_lane1,
  input  tvalc_pkg::lane_t    in_first_lane2,
  input  tvalc_pkg::lane_t    in_first_lane3,
  input  tvalc_pkg::mask_t    in_first_active,
  input  tvalc_pkg::lane_t    in_second_lane0,
  input  tvalc_pkg::lane_t    in_second_lane1,
  input  tvalc_pkg::lane_t    in_second_lane2,
  input  tvalc_pkg::lane_t    in_second_lane3,
  input  tvalc_pkg::mask_t    in_second_active,
  output logic                out_valid,
  input  logic                out_ready,
  output tvalc_pkg::lane_t    out_packed_lane0,
  output tvalc_pkg::lane_t    out_packed_lane1,
  output tvalc_pkg::lane_t    out_packed_lane2,
  output tvalc_pkg::lane_t    out_packed_lane3,
  output tvalc_pkg::mask_t    out_packed_valid,
  output tvalc_pkg::lane_t    out_rest_lane0,
  output tvalc_pkg::lane_t    out_rest_lane1,
  output tvalc_pkg::lane_t    out_rest_lane2,
  output tvalc_pkg::lane_t    out_rest_lane3,
  output tvalc_pkg::mask_t    out_rest_valid
);

  `include "two_vector_active_lane_consolidation_assert.svh"

  logic                 s1_valid_r;
  tvalc_pkg::vec_t      a_r;
  tvalc_pkg::vec_t      b_r;
  tvalc_pkg::mask_t     am_r;
  tvalc_pkg::mask_t     bm_r;

  logic                 out_valid_r;
  tvalc_pkg::vec_t      packed_r;
  tvalc_pkg::vec_t      rest_r;
  tvalc_pkg::mask_t     pvalid_r;
  tvalc_pkg::mask_t     rvalid_r;

  tvalc_pkg::vec_t      packed_nxt;
  tvalc_pkg::vec_t      rest_nxt;
  tvalc_pkg::mask_t     pvalid_nxt;
  tvalc_pkg::mask_t     rvalid_nxt;

  tvalc_pkg::compact_t  ca;
  tvalc_pkg::compact_t  cb;
  logic                 s2_load;

  assign s2_load  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s2_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_r  <= {in_first_lane3, in_first_lane2, in_first_lane1, in_first_lane0};
      b_r  <= {in_second_lane3, in_second_lane2, in_second_lane1, in_second_lane0};
      am_r <= in_first_active;
      bm_r <= in_second_active;
    end
  end

  tvalc_compact u_compact_a (
    .src  (a_r),
    .mask (am_r),
    .res  (ca)
  );

  tvalc_compact u_compact_b (
    .src  (b_r),
    .mask (bm_r),
    .res  (cb)
  );

  always_comb begin
    tvalc_pkg::vec_t             seq_b;
    tvalc_pkg::cnt_t             off;
    tvalc_pkg::cnt_t             inact_cnt_a;
    logic [tvalc_pkg::CNT_W:0]   total;
    tvalc_pkg::cnt_t             ci;
    // Second vector as actives followed by inactives.
    for (int k = 0; k < tvalc_pkg::LANES; k++) begin
      off = tvalc_pkg::CNT_W'(k) - cb.act_cnt;
      if (tvalc_pkg::CNT_W'(k) < cb.act_cnt) begin
        seq_b[k] = cb.act[k];
      end else begin
        seq_b[k] = cb.inact[off[tvalc_pkg::IDX_W-1:0]];
      end
    end
    inact_cnt_a = tvalc_pkg::CNT_W'(tvalc_pkg::LANES) - ca.act_cnt;
    total       = {1'b0, ca.act_cnt} + {1'b0, cb.act_cnt};
    for (int i = 0; i < tvalc_pkg::LANES; i++) begin
      ci  = tvalc_pkg::CNT_W'(i);
      off = ci - ca.act_cnt;
      if (ci < ca.act_cnt) begin
        packed_nxt[i] = ca.act[i];
      end else begin
        packed_nxt[i] = seq_b[off[tvalc_pkg::IDX_W-1:0]];
      end
      if (ci < inact_cnt_a) begin
        rest_nxt[i] = ca.inact[i];
      end else begin
        rest_nxt[i] = seq_b[i];
      end
      pvalid_nxt[i] = {1'b0, ci} < total;
      // Overflow actives of the second vector land above the first's inactives.
      rvalid_nxt[i] = (ci >= inact_cnt_a) && (ci < cb.act_cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      packed_r <= packed_nxt;
      rest_r   <= rest_nxt;
      pvalid_r <= pvalid_nxt;
      rvalid_r <= rvalid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_packed_lane0 = packed_r[0];
  assign out_packed_lane1 = packed_r[1];
  assign out_packed_lane2 = packed_r[2];
  assign out_packed_lane3 = packed_r[3];
  assign out_packed_valid = pvalid_r;
  assign out_rest_lane0   = rest_r[0];
  assign out_rest_lane1   = rest_r[1];
  assign out_rest_lane2   = rest_r[2];
  assign out_rest_lane3   = rest_r[3];
  assign out_rest_valid   = rvalid_r;

  `TVALC_ASSERT_SAME(a_pvalid_low_ones, out_valid,
    (out_packed_valid & (out_packed_valid + tvalc_pkg::mask_t'(1))) == '0,
    "packed_valid is not a run of low ones")
  `TVALC_ASSERT_SAME(a_rest_needs_full, out_valid && (out_rest_valid != '0),
    out_packed_valid == '1, "rest lanes flagged while packed result not full")
  `TVALC_ASSERT_NEXT(a_s1_holds, s1_valid_r && !s2_load, s1_valid_r,
    "input register dropped a stalled transaction")
  `TVALC_ASSERT_SAME(a_ready_when_empty, !out_valid_r, in_ready,
    "input stalled while the result register is empty")

endmodule
